### rtl/chd_pkg.sv
// Shared constants, status codes, state encoding and control structs
// for the cyclic Hamming (15,11) error-trapping decoder. No dependencies.
`default_nettype none

package chd_pkg;

    // Code geometry
    localparam int CODE_BITS   = 15;
    localparam int DATA_BITS   = 11;
    localparam int CHECK_BITS  = 4;
    localparam int SYN_BITS    = 4;
    localparam int CNT_W       = 4;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;
    localparam int STATUS_W    = 2;

    // Generator x^4+x^3+1, aligned to the top of the word for long division
    localparam logic [CODE_BITS-1:0] POLY_ALIGNED = 15'h6400;
    localparam logic [CODE_BITS-1:0] TOP_BIT      = 15'h4000;
    // Same generator for the 4-bit syndrome shift register
    localparam logic [SYN_BITS:0]    GEN_POLY     = 5'h19;

    // Last division step and rotation bound
    localparam logic [CNT_W-1:0] DIV_LAST   = 4'd14;
    localparam logic [CNT_W-1:0] TURN_LIMIT = 4'd15;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_NONE  = 2'd0,
        STATUS_FIXED = 2'd1,
        STATUS_FAIL  = 2'd2
    } chd_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_TRAP,
        ST_FINISH
    } chd_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture a new codeword
        logic div_step;   // one long-division step
        logic trap_step;  // rotate word, advance syndrome
        logic fix;        // apply correction, settle status
        logic out_load;   // rotate back into the output register
    } chd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_done;   // current division step is the last one
        logic syn_zero;   // syndrome is zero
        logic trapped;    // syndrome weight at most one
        logic turns_full; // rotation bound reached
        logic out_busy;   // output register holds an untaken result
    } chd_sts_t;

endpackage

`default_nettype wire

### rtl/chd_datapath.sv
// Datapath: word and division registers, syndrome shift register,
// step counter and output register. Depends on chd_pkg.
`default_nettype none

module chd_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire chd_pkg::chd_cmd_t             cmd,
    output chd_pkg::chd_sts_t                  sts,
    input  wire logic [chd_pkg::CODE_BITS-1:0] in_word,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [chd_pkg::DATA_BITS-1:0]      out_data,
    output logic [chd_pkg::STATUS_W-1:0]       out_status
);
    import chd_pkg::*;

    logic [CODE_BITS-1:0]   word_reg, word_next;
    logic [CODE_BITS-1:0]   div_reg, div_next;
    logic [SYN_BITS-1:0]    syn_reg, syn_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    chd_status_t            stat_reg, stat_next;
    logic [DATA_BITS-1:0]   odata_reg, odata_next;
    chd_status_t            ostat_reg, ostat_next;
    logic                   ovalid_reg, ovalid_next;

    logic [CODE_BITS-1:0]   div_red;
    logic [CODE_BITS-1:0]   div_shift;
    logic [SYN_BITS:0]      syn_shift;
    logic [CODE_BITS-1:0]   word_rot;
    logic [2*CODE_BITS-1:0] word_dbl;
    logic [CODE_BITS-1:0]   word_back;
    logic                   trapped;

    // One long-division step: reduce on the top bit, then shift
    assign div_red   = ((div_reg & TOP_BIT) != '0) ? (div_reg ^ POLY_ALIGNED) : div_reg;
    assign div_shift = {div_red[CODE_BITS-2:0], 1'b0};

    // Syndrome of the word rotated by one is x times the syndrome mod g
    assign syn_shift = {syn_reg, 1'b0} ^ (syn_reg[SYN_BITS-1] ? GEN_POLY : '0);

    assign word_rot  = {word_reg[CODE_BITS-2:0], word_reg[CODE_BITS-1]};

    // Rotate right by the number of turns taken
    assign word_dbl  = {word_reg, word_reg} >> cnt_reg;
    assign word_back = word_dbl[CODE_BITS-1:0];

    // Weight at most one
    assign trapped   = (syn_reg & (syn_reg - SYN_BITS'(1))) == '0;

    // Status to controller
    assign sts.div_done   = (cnt_reg == DIV_LAST);
    assign sts.syn_zero   = (syn_reg == '0);
    assign sts.trapped    = trapped;
    assign sts.turns_full = (cnt_reg == TURN_LIMIT);
    assign sts.out_busy   = ovalid_reg && !out_ready;

    // Next-value logic
    always_comb begin
        word_next   = word_reg;
        div_next    = div_reg;
        syn_next    = syn_reg;
        cnt_next    = cnt_reg;
        stat_next   = stat_reg;
        odata_next  = odata_reg;
        ostat_next  = ostat_reg;
        ovalid_next = ovalid_reg;

        if (cmd.load) begin
            word_next = in_word;
            div_next  = in_word;
            cnt_next  = '0;
        end

        if (cmd.div_step) begin
            div_next = div_shift;
            if (cnt_reg == DIV_LAST) begin
                cnt_next = '0;
                syn_next = div_shift[CODE_BITS-1 -: SYN_BITS];
            end else begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end

        if (cmd.trap_step) begin
            word_next = word_rot;
            syn_next  = syn_shift[SYN_BITS-1:0];
            cnt_next  = cnt_reg + CNT_W'(1);
        end

        // Correction lands on the bit under the syndrome, bits 14..11
        if (cmd.fix) begin
            priority if (syn_reg == '0) begin
                stat_next = STATUS_NONE;
            end else if (trapped) begin
                word_next = word_reg ^ {syn_reg, {(CODE_BITS-SYN_BITS){1'b0}}};
                stat_next = STATUS_FIXED;
            end else begin
                stat_next = STATUS_FAIL;
            end
        end

        // Output register
        if (cmd.out_load) begin
            odata_next  = word_back[CODE_BITS-1:CHECK_BITS];
            ostat_next  = stat_reg;
            ovalid_next = 1'b1;
        end else if (out_ready) begin
            ovalid_next = 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        word_reg  <= word_next;
        div_reg   <= div_next;
        syn_reg   <= syn_next;
        cnt_reg   <= cnt_next;
        stat_reg  <= stat_next;
        odata_reg <= odata_next;
        ostat_reg <= ostat_next;
    end

    // Output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else begin
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid  = ovalid_reg;
    assign out_data   = odata_reg;
    assign out_status = ostat_reg;

endmodule

`default_nettype wire

### rtl/chd_ctrl.sv
// Controller state machine: sequences division, trap search and
// output load for one codeword at a time. Depends on chd_pkg.
`default_nettype none

module chd_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire chd_pkg::chd_sts_t sts,
    output chd_pkg::chd_cmd_t      cmd
);
    import chd_pkg::*;

    chd_state_t state_reg, state_next;
    logic       trap_end;

    // Search ends on zero, on weight one, or at the rotation bound
    assign trap_end = sts.syn_zero || sts.trapped || sts.turns_full;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (sts.div_done) state_next = ST_TRAP;
            end
            ST_TRAP: begin
                if (trap_end) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!sts.out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
            end
            ST_TRAP: begin
                cmd.fix       = trap_end;
                cmd.trap_step = !trap_end;
            end
            ST_FINISH: begin
                cmd.out_load = !sts.out_busy;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/cyclic_hamming_15_11_decoder.sv
// Processing: each accepted codeword is divided bit-serially, then trap-searched by rotation (t = rotations, 0..15).
// One codeword at a time: a new request is taken only after the previous one has passed
// the bit-serial division, the one-rotation-per-cycle trap search and the output load.
// A finished result waits in the output register while the next codeword is taken.
// Reset: aresetn synchronous active low; clears the state machine and output valid.
`default_nettype none

module cyclic_hamming_15_11_decoder (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [chd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [14:0] codeword
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [chd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,   // [10:0] data_bits
    output logic [chd_pkg::STATUS_W-1:0]         m_axis_tuser    // [1:0] status
);
    import chd_pkg::*;

    chd_cmd_t             cmd;
    chd_sts_t             sts;
    logic [DATA_BITS-1:0] data_bits;

    chd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    chd_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_word    (s_axis_tdata[CODE_BITS-1:0]),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_data   (data_bits),
        .out_status (m_axis_tuser)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-DATA_BITS){1'b0}}, data_bits};

`ifndef SYNTH
    // Busy after taking a request
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("decoder ready right after accepting a request");

    // Never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_axis_tvalid && !m_axis_tready))
        else $error("output register loaded while holding a result");

    // No rotation past the bound
    a_turn_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.trap_step |-> !sts.turns_full)
        else $error("trap search rotated past the bound");

    // Perfect code: every nonzero syndrome is trapped
    a_always_trapped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser != STATUS_FAIL))
        else $error("untrapped error reported");
`endif

endmodule

`default_nettype wire
